@@ rtl/olde_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// olde_pkg
// Shared constants and types of the ordered list deque engine.
// ============================================================================
package olde_pkg;

   // Default sizes handed to the top level parameters.
   localparam int SLOTS_DEF      = 64;
   localparam int VALUE_BITS_DEF = 32;

   // Request codes. Codes above the count request behave like it.
   localparam logic [3:0] REQ_INS_HEAD  = 4'd0;
   localparam logic [3:0] REQ_INS_TAIL  = 4'd1;
   localparam logic [3:0] REQ_PEEK_HEAD = 4'd2;
   localparam logic [3:0] REQ_PEEK_TAIL = 4'd3;
   localparam logic [3:0] REQ_POP_HEAD  = 4'd4;
   localparam logic [3:0] REQ_POP_TAIL  = 4'd5;
   localparam logic [3:0] REQ_MOVE_TAIL = 4'd6;
   localparam logic [3:0] REQ_REMOVE    = 4'd7;
   localparam logic [3:0] REQ_COUNT     = 4'd8;

   // Response status codes.
   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_EMPTY      = 2'd1;
   localparam logic [1:0] STS_FULL       = 2'd2;
   localparam logic [1:0] STS_BAD_HANDLE = 2'd3;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_EXEC = 2'b10
   } fsm_type;

   // Write strobes broadcast to every slot cell during the write-back cycle.
   typedef struct packed {
      logic wr_value;   // store the request value in the target slot
      logic set_used;   // mark the target slot in use
      logic clr_used;   // mark the target slot free
      logic wr_self;    // load both links of the target slot
      logic nx_a_en;    // next-link write, lowest priority
      logic nx_b_en;    // next-link write, above nx_a
      logic pv_a_en;    // prev-link write, below the self write
   } cell_cmd_type;

endpackage

@@ rtl/ordered_list_deque_engine.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ordered_list_deque_engine
// Fixed-capacity doubly linked ordered list, usable as a deque or LRU order.
//
// Each request transaction returns one response transaction. In the cycle
// a request is accepted, the slot it concerns (head, tail or the given
// handle) is selected in the row of slot cells and its in-use flag, value
// and both links are registered; in the next cycle the new links are
// written back to that slot and its neighbors, the free-slot stack shifts,
// and the response register is loaded. Because of that read-then-write of
// the link cells, no new request is taken during the write-back cycle, and
// one is taken only while the response register is empty or being emptied
// in the same cycle. Inserts report the slot they took as the handle; a pop
// or remove returns the slot to the top of the free stack, so it is the
// next one handed out. Peeks and pops on an empty list, inserts into a full
// list and handles not in use report an error status and leave the list
// untouched. The free stack and in-use flags are set by reset; no clearing
// pass is needed.
// ============================================================================
module ordered_list_deque_engine #(
   parameter int SLOTS      = olde_pkg::SLOTS_DEF,
   parameter int VALUE_BITS = olde_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_type,
   input  logic [VALUE_BITS-1:0]        req_value,
   input  logic [$clog2(SLOTS)-1:0]     req_handle,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [VALUE_BITS-1:0]        rsp_value_out,
   output logic [$clog2(SLOTS)-1:0]     rsp_handle_out,
   output logic [$clog2(SLOTS+1)-1:0]   rsp_count
);

   localparam int IW = $clog2(SLOTS);      // slot index width
   localparam int LW = IW + 1;             // link width, holds the none code
   localparam int CW = $clog2(SLOTS + 1);  // entry count width
   localparam int VW = VALUE_BITS;

   // Link code meaning "no neighbor".
   localparam logic [LW-1:0] NONE  = LW'(SLOTS);
   localparam logic [CW-1:0] FULLC = CW'(SLOTS);

   // ------------------------------------------------------------------------
   // Control state.
   // ------------------------------------------------------------------------
   olde_pkg::fsm_type state_ff;
   olde_pkg::fsm_type state_in;

   logic [LW-1:0] head_ff;
   logic [LW-1:0] head_in;
   logic [LW-1:0] tail_ff;
   logic [LW-1:0] tail_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // Request held for the write-back cycle, and the slot fields read for it.
   logic [3:0]    rq_type_ff;
   logic [VW-1:0] rq_value_ff;
   logic [IW-1:0] rq_handle_ff;
   logic          f_used_ff;
   logic [VW-1:0] f_value_ff;
   logic [LW-1:0] f_next_ff;
   logic [LW-1:0] f_prev_ff;

   // Response register.
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [VW-1:0] rsp_value_ff;
   logic [IW-1:0] rsp_handle_ff;
   logic [CW-1:0] rsp_count_ff;

   logic accept;
   logic exec;

   assign exec      = (state_ff == olde_pkg::FSM_EXEC);
   assign req_ready = (state_ff == olde_pkg::FSM_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // ------------------------------------------------------------------------
   // Slot selection for the read cycle, from the request ports and the head and tail registers.
   // ------------------------------------------------------------------------
   logic [IW-1:0] sel_idx;

   always_comb begin
      case (req_type)
         olde_pkg::REQ_PEEK_HEAD, olde_pkg::REQ_POP_HEAD: begin
            sel_idx = head_ff[IW-1:0];
         end
         olde_pkg::REQ_PEEK_TAIL, olde_pkg::REQ_POP_TAIL: begin
            sel_idx = tail_ff[IW-1:0];
         end
         default: begin
            sel_idx = req_handle;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Write-back decisions. Every broadcast write is gated by exec below.
   // ------------------------------------------------------------------------
   olde_pkg::cell_cmd_type cmd_raw;
   olde_pkg::cell_cmd_type cmd;
   logic [IW-1:0] tgt_idx;
   logic [LW-1:0] self_next;
   logic [LW-1:0] self_prev;
   logic [IW-1:0] nx_a_idx;
   logic [LW-1:0] nx_a_data;
   logic [IW-1:0] nx_b_idx;
   logic [LW-1:0] nx_b_data;
   logic [IW-1:0] pv_a_idx;
   logic [LW-1:0] pv_a_data;
   logic          fs_push_raw;
   logic          fs_pop_raw;
   logic          fs_push;
   logic          fs_pop;
   logic [IW-1:0] push_slot;
   logic [IW-1:0] fs_top;
   logic [1:0]    sts;
   logic [VW-1:0] vout;
   logic [IW-1:0] hout;

   logic [LW-1:0] fs_top_link;
   logic [LW-1:0] hnd_link;
   logic [LW-1:0] end_link;
   logic [LW-1:0] rel_link;
   logic [LW-1:0] tail_det;
   logic          list_full;
   logic          list_empty;
   logic          hnd_bad;
   logic          end_is_tail;
   logic          is_pop;

   assign fs_top_link = {1'b0, fs_top};
   assign hnd_link    = {1'b0, rq_handle_ff};
   assign list_full   = (count_ff == FULLC);
   assign list_empty  = (count_ff == '0);
   assign hnd_bad     = (hnd_link >= NONE) || !f_used_ff;
   assign end_is_tail = rq_type_ff inside {olde_pkg::REQ_PEEK_TAIL, olde_pkg::REQ_POP_TAIL};
   assign is_pop      = rq_type_ff inside {olde_pkg::REQ_POP_HEAD, olde_pkg::REQ_POP_TAIL};
   assign end_link    = end_is_tail ? tail_ff : head_ff;
   assign rel_link    = is_pop ? end_link : hnd_link;
   // Tail after the handled entry has been unlinked, used by move to tail and remove.
   assign tail_det    = (tail_ff == hnd_link) ? f_prev_ff : tail_ff;

   always_comb begin
      cmd_raw     = '0;
      tgt_idx     = rel_link[IW-1:0];
      self_next   = NONE;
      self_prev   = NONE;
      nx_a_idx    = f_prev_ff[IW-1:0];
      nx_a_data   = f_next_ff;
      nx_b_idx    = tail_det[IW-1:0];
      nx_b_data   = hnd_link;
      pv_a_idx    = f_next_ff[IW-1:0];
      pv_a_data   = f_prev_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      fs_push_raw = 1'b0;
      fs_pop_raw  = 1'b0;
      push_slot   = rel_link[IW-1:0];
      sts         = olde_pkg::STS_OK;
      vout        = '0;
      hout        = '0;
      case (rq_type_ff)
         olde_pkg::REQ_INS_HEAD, olde_pkg::REQ_INS_TAIL: begin
            if (list_full) begin
               sts = olde_pkg::STS_FULL;
            end else begin
               tgt_idx          = fs_top;
               cmd_raw.wr_value = 1'b1;
               cmd_raw.set_used = 1'b1;
               cmd_raw.wr_self  = 1'b1;
               fs_pop_raw       = 1'b1;
               count_in         = count_ff + CW'(1);
               hout             = fs_top;
               if (rq_type_ff == olde_pkg::REQ_INS_HEAD) begin
                  self_next       = head_ff;
                  self_prev       = NONE;
                  pv_a_idx        = head_ff[IW-1:0];
                  pv_a_data       = fs_top_link;
                  cmd_raw.pv_a_en = (head_ff != NONE);
                  head_in         = fs_top_link;
                  if (head_ff == NONE) begin
                     tail_in = fs_top_link;
                  end
               end else begin
                  self_next       = NONE;
                  self_prev       = tail_ff;
                  nx_a_idx        = tail_ff[IW-1:0];
                  nx_a_data       = fs_top_link;
                  cmd_raw.nx_a_en = (tail_ff != NONE);
                  tail_in         = fs_top_link;
                  if (tail_ff == NONE) begin
                     head_in = fs_top_link;
                  end
               end
            end
         end
         olde_pkg::REQ_PEEK_HEAD, olde_pkg::REQ_PEEK_TAIL,
         olde_pkg::REQ_POP_HEAD, olde_pkg::REQ_POP_TAIL: begin
            if (list_empty) begin
               sts = olde_pkg::STS_EMPTY;
            end else begin
               vout = f_value_ff;
               hout = end_link[IW-1:0];
               if (is_pop) begin
                  cmd_raw.clr_used = 1'b1;
                  cmd_raw.nx_a_en  = (f_prev_ff != NONE);
                  cmd_raw.pv_a_en  = (f_next_ff != NONE);
                  fs_push_raw      = 1'b1;
                  count_in         = count_ff - CW'(1);
                  if (head_ff == rel_link) begin
                     head_in = f_next_ff;
                  end
                  if (tail_ff == rel_link) begin
                     tail_in = f_prev_ff;
                  end
               end
            end
         end
         olde_pkg::REQ_MOVE_TAIL, olde_pkg::REQ_REMOVE: begin
            if (hnd_bad) begin
               sts = olde_pkg::STS_BAD_HANDLE;
            end else begin
               cmd_raw.nx_a_en = (f_prev_ff != NONE);
               cmd_raw.pv_a_en = (f_next_ff != NONE);
               if (head_ff == hnd_link) begin
                  head_in = f_next_ff;
               end
               if (rq_type_ff == olde_pkg::REQ_REMOVE) begin
                  cmd_raw.clr_used = 1'b1;
                  fs_push_raw      = 1'b1;
                  count_in         = count_ff - CW'(1);
                  tail_in          = tail_det;
               end else begin
                  // Unlink, then attach behind what is left of the list.
                  cmd_raw.wr_self = 1'b1;
                  cmd_raw.nx_b_en = (tail_det != NONE);
                  self_next       = NONE;
                  self_prev       = tail_det;
                  tail_in         = hnd_link;
                  if (tail_det == NONE) begin
                     head_in = hnd_link;
                  end
               end
            end
         end
         olde_pkg::REQ_COUNT: begin
            sts = olde_pkg::STS_OK;
         end
         default: begin
            sts = olde_pkg::STS_OK;
         end
      endcase
   end

   assign cmd     = exec ? cmd_raw : '0;
   assign fs_push = exec && fs_push_raw;
   assign fs_pop  = exec && fs_pop_raw;

   // ------------------------------------------------------------------------
   // Row of slot cells, and the OR-combine of the selected cell.
   // ------------------------------------------------------------------------
   logic          cell_used  [SLOTS];
   logic [VW-1:0] cell_value [SLOTS];
   logic [LW-1:0] cell_next  [SLOTS];
   logic [LW-1:0] cell_prev  [SLOTS];

   for (genvar k = 0; k < SLOTS; k++) begin : g_slot
      olde_slot_cell #(
         .IW    (IW),
         .LW    (LW),
         .VW    (VW),
         .INDEX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .tgt_idx   (tgt_idx),
         .wr_value  (rq_value_ff),
         .self_next (self_next),
         .self_prev (self_prev),
         .nx_a_idx  (nx_a_idx),
         .nx_a_data (nx_a_data),
         .nx_b_idx  (nx_b_idx),
         .nx_b_data (nx_b_data),
         .pv_a_idx  (pv_a_idx),
         .pv_a_data (pv_a_data),
         .sel_idx   (sel_idx),
         .rd_used   (cell_used[k]),
         .rd_value  (cell_value[k]),
         .rd_next   (cell_next[k]),
         .rd_prev   (cell_prev[k])
      );
   end

   logic          rd_used;
   logic [VW-1:0] rd_value;
   logic [LW-1:0] rd_next;
   logic [LW-1:0] rd_prev;

   always_comb begin
      rd_used  = 1'b0;
      rd_value = '0;
      rd_next  = '0;
      rd_prev  = '0;
      for (int k = 0; k < SLOTS; k++) begin
         rd_used  = rd_used | cell_used[k];
         rd_value = rd_value | cell_value[k];
         rd_next  = rd_next | cell_next[k];
         rd_prev  = rd_prev | cell_prev[k];
      end
   end

   // ------------------------------------------------------------------------
   // Free-slot stack as a shifting row of cells; cell zero is the top.
   // After reset the top holds the highest slot number.
   // ------------------------------------------------------------------------
   logic [IW-1:0] fs_slot [SLOTS];

   for (genvar k = 0; k < SLOTS; k++) begin : g_free
      logic [IW-1:0] left_slot;
      logic [IW-1:0] right_slot;
      if (k == 0) begin : g_top
         assign left_slot = push_slot;
      end else begin : g_mid
         assign left_slot = fs_slot[k-1];
      end
      if (k == SLOTS - 1) begin : g_bottom
         assign right_slot = fs_slot[k];
      end else begin : g_inner
         assign right_slot = fs_slot[k+1];
      end
      olde_free_cell #(
         .IW   (IW),
         .INIT (SLOTS - 1 - k)
      ) u_free (
         .clock      (clock),
         .reset      (reset),
         .push       (fs_push),
         .pop        (fs_pop),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .slot       (fs_slot[k])
      );
   end

   assign fs_top = fs_slot[0];

   // ------------------------------------------------------------------------
   // Sequencing: accept and read in the same cycle, write back in the next.
   // ------------------------------------------------------------------------
   always_comb begin
      case (state_ff)
         olde_pkg::FSM_IDLE: begin
            state_in = accept ? olde_pkg::FSM_EXEC : olde_pkg::FSM_IDLE;
         end
         olde_pkg::FSM_EXEC: begin
            state_in = olde_pkg::FSM_IDLE;
         end
         default: begin
            state_in = olde_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olde_pkg::FSM_IDLE;
         head_ff      <= NONE;
         tail_ff      <= NONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rq_type_ff   <= req_type;
         rq_value_ff  <= req_value;
         rq_handle_ff <= req_handle;
         f_used_ff    <= rd_used;
         f_value_ff   <= rd_value;
         f_next_ff    <= rd_next;
         f_prev_ff    <= rd_prev;
      end
      if (exec) begin
         rsp_status_ff <= sts;
         rsp_value_ff  <= vout;
         rsp_handle_ff <= hout;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_count      = rsp_count_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULLC)
      else $error("entry count beyond capacity");

   ap_ends_match_count: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) == (head_ff == NONE)) && ((count_ff == '0) == (tail_ff == NONE)))
      else $error("head or tail disagrees with the entry count");

   ap_single_entry: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CW'(1)) |-> (head_ff == tail_ff))
      else $error("single entry list with distinct head and tail");

   ap_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (exec && !rsp_valid_ff))
      else $error("accepted transaction without free response register");

   ap_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == olde_pkg::FSM_EXEC))
      else $error("response raised outside the write-back cycle");

endmodule

@@ rtl/olde_slot_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// olde_slot_cell
// One list slot: stored value, next and prev links, and the in-use flag.
// ============================================================================
module olde_slot_cell #(
   parameter int IW    = 6,
   parameter int LW    = 7,
   parameter int VW    = 32,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  olde_pkg::cell_cmd_type cmd,
   input  logic [IW-1:0]         tgt_idx,
   input  logic [VW-1:0]         wr_value,
   input  logic [LW-1:0]         self_next,
   input  logic [LW-1:0]         self_prev,
   input  logic [IW-1:0]         nx_a_idx,
   input  logic [LW-1:0]         nx_a_data,
   input  logic [IW-1:0]         nx_b_idx,
   input  logic [LW-1:0]         nx_b_data,
   input  logic [IW-1:0]         pv_a_idx,
   input  logic [LW-1:0]         pv_a_data,
   input  logic [IW-1:0]         sel_idx,
   output logic                  rd_used,
   output logic [VW-1:0]         rd_value,
   output logic [LW-1:0]         rd_next,
   output logic [LW-1:0]         rd_prev
);

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic          used_ff;
   logic          used_in;
   logic [VW-1:0] value_ff;
   logic [VW-1:0] value_in;
   logic [LW-1:0] next_ff;
   logic [LW-1:0] next_in;
   logic [LW-1:0] prev_ff;
   logic [LW-1:0] prev_in;
   logic          is_tgt;
   logic          is_sel;

   assign is_tgt = (tgt_idx == MY_IDX);
   assign is_sel = (sel_idx == MY_IDX);

   always_comb begin
      used_in  = used_ff;
      value_in = value_ff;
      next_in  = next_ff;
      prev_in  = prev_ff;
      if (is_tgt && cmd.set_used) begin
         used_in = 1'b1;
      end else if (is_tgt && cmd.clr_used) begin
         used_in = 1'b0;
      end
      if (is_tgt && cmd.wr_value) begin
         value_in = wr_value;
      end
      // Later steps of an update win when two writes land on the same link.
      if (is_tgt && cmd.wr_self) begin
         next_in = self_next;
      end else if (cmd.nx_b_en && (nx_b_idx == MY_IDX)) begin
         next_in = nx_b_data;
      end else if (cmd.nx_a_en && (nx_a_idx == MY_IDX)) begin
         next_in = nx_a_data;
      end
      if (is_tgt && cmd.wr_self) begin
         prev_in = self_prev;
      end else if (cmd.pv_a_en && (pv_a_idx == MY_IDX)) begin
         prev_in = pv_a_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      next_ff  <= next_in;
      prev_ff  <= prev_in;
   end

   // Unselected cells drive zero so the row can be OR-combined.
   assign rd_used  = is_sel & used_ff;
   assign rd_value = is_sel ? value_ff : '0;
   assign rd_next  = is_sel ? next_ff : '0;
   assign rd_prev  = is_sel ? prev_ff : '0;

endmodule

@@ rtl/olde_free_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// olde_free_cell
// One stage of the free-slot stack; shifts toward the top on a pop and away
// from it on a push.
// ============================================================================
module olde_free_cell #(
   parameter int IW   = 6,
   parameter int INIT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic          pop,
   input  logic [IW-1:0] left_slot,
   input  logic [IW-1:0] right_slot,
   output logic [IW-1:0] slot
);

   logic [IW-1:0] slot_ff;
   logic [IW-1:0] slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (push) begin
         slot_in = left_slot;
      end else if (pop) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= IW'(INIT);
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule
